@@ rtl/core/bbc_pkg.sv @@
// Shared types and constants for the band-pass biquad cascade.
// No dependencies; imported by bbc_mac and biquad_bandpass_cascade.
`timescale 1ns / 1ps

package bbc_pkg;

  // Default widths of the sample path and the coefficient fraction
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_FRAC_BITS = 16;

  // Coefficient registers are fixed Q3.16 words
  localparam int COEF_BITS    = 20;
  localparam int CFG_IDX_BITS = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_B0  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_A1  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_A2  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_B0 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_A1 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_A2 = 3'd5;

  // Tap sequence within one biquad pass
  localparam int TAP_BITS = 3;
  localparam logic [TAP_BITS-1:0] TAP_X0   = 3'd0;  // b0 * x
  localparam logic [TAP_BITS-1:0] TAP_X1   = 3'd1;  // +/-2 b0 * x[n-1]
  localparam logic [TAP_BITS-1:0] TAP_X2   = 3'd2;  // b0 * x[n-2]
  localparam logic [TAP_BITS-1:0] TAP_Y1   = 3'd3;  // -a1 * y[n-1]
  localparam logic [TAP_BITS-1:0] TAP_Y2   = 3'd4;  // -a2 * y[n-2]
  localparam logic [TAP_BITS-1:0] TAP_LAST = 3'd5;  // drain last product

  // Control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic issue;  // a product is launched this cycle
    logic first;  // product starts a new sum
    logic dbl;    // product is scaled by two
    logic neg;    // product is subtracted
  } mac_ctrl_t;

endpackage

@@ rtl/core/bbc_mac.sv @@
// Shared multiply-accumulate unit with rounding and saturation.
// Depends on bbc_pkg (mac_ctrl_t, COEF_BITS).
`timescale 1ns / 1ps

module bbc_mac import bbc_pkg::*; #(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] operand,
  input  logic signed [COEF_BITS-1:0]   coef,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    signed'(ACC_W'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PROD_W-1:0] prod;
  mac_ctrl_t                prod_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [ACC_W-1:0]  shifted;

  // Product register
  always_ff @(posedge clk) begin
    prod <= operand * coef;
    if (rst) begin
      prod_ctrl <= '0;
    end else begin
      prod_ctrl <= ctrl;
    end
  end

  // Scale and sign of the registered product
  always_comb begin
    term   = ACC_W'(prod);
    if (prod_ctrl.dbl) begin
      term = term <<< 1;
    end
    addend = prod_ctrl.neg ? -term : term;
  end

  // Accumulator, restarted by the first product of a pass
  always_ff @(posedge clk) begin
    if (prod_ctrl.issue) begin
      acc <= (prod_ctrl.first ? '0 : acc) + addend;
    end
  end

  // Round half up, drop the fraction, clamp to the sample range
  always_comb begin
    rsum    = acc + ROUND_BIAS;
    shifted = rsum >>> COEF_FRAC_BITS;
    if (shifted > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ rtl/core/biquad_bandpass_cascade.sv @@
// Band-pass filter: Direct Form I low-pass biquad followed by a high-pass biquad.
// Depends on bbc_pkg and bbc_mac (one shared multiplier for all ten products).
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+------------------------------------
//   s_*     | in        | s_tvalid/s_tready  | s_tdata: sample_in
//   m_*     | out       | m_tvalid/m_tready  | m_tdata: sample_out
//   cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (coefficients)
//
// Each word keeps s_tready low from acceptance until the block is back in idle, so
// no new word goes in before the last is through: two passes through the shared
// multiplier-accumulator, each with a round/saturate step, then the idle state that
// takes the next word. The result enters the output register in the final step.
// A result waiting on m_tready does not block the next input; the next word only
// holds in its final step until the output register is free.
// Reset (rst, synchronous) zeroes the coefficients and all filter history.
`timescale 1ns / 1ps

module biquad_bandpass_cascade import bbc_pkg::*; #(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [TDATA_W-1:0]      s_tdata,    // [SAMPLE_BITS-1:0] sample_in
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [TDATA_W-1:0]      m_tdata,    // [SAMPLE_BITS-1:0] sample_out
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LP_MAC = 5'b00010,
    ST_LP_RND = 5'b00100,
    ST_HP_MAC = 5'b01000,
    ST_HP_RND = 5'b10000
  } state_t;

  state_t                         state;
  logic [TAP_BITS-1:0]            tap;

  logic signed [COEF_BITS-1:0]    low_b0, low_a1, low_a2;
  logic signed [COEF_BITS-1:0]    high_b0, high_a1, high_a2;

  logic signed [SAMPLE_BITS-1:0]  x_in;
  logic signed [SAMPLE_BITS-1:0]  lp_in_hist  [2];
  logic signed [SAMPLE_BITS-1:0]  lp_out_hist [2];
  logic signed [SAMPLE_BITS-1:0]  hp_in_hist  [2];
  logic signed [SAMPLE_BITS-1:0]  hp_out_hist [2];
  logic [SAMPLE_BITS-1:0]         out_sample;

  mac_ctrl_t                      mac_ctrl;
  logic signed [SAMPLE_BITS-1:0]  mac_operand;
  logic signed [COEF_BITS-1:0]    mac_coef;
  logic signed [SAMPLE_BITS-1:0]  mac_result;
  logic                           in_hp;
  logic                           in_mac;
  logic                           out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = TDATA_W'(out_sample);
  assign out_free  = !m_tvalid || m_tready;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_b0  <= '0;
      low_a1  <= '0;
      low_a2  <= '0;
      high_b0 <= '0;
      high_a1 <= '0;
      high_a2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_B0:  low_b0  <= cfg_data;
        REG_LOW_A1:  low_a1  <= cfg_data;
        REG_LOW_A2:  low_a2  <= cfg_data;
        REG_HIGH_B0: high_b0 <= cfg_data;
        REG_HIGH_A1: high_a1 <= cfg_data;
        REG_HIGH_A2: high_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand and coefficient select for the current tap
  always_comb begin
    in_hp  = (state == ST_HP_MAC);
    in_mac = (state == ST_LP_MAC) || in_hp;
    mac_ctrl.issue = in_mac && (tap != TAP_LAST);
    mac_ctrl.first = (tap == TAP_X0);
    mac_ctrl.dbl   = (tap == TAP_X1);
    mac_ctrl.neg   = (tap == TAP_Y1) || (tap == TAP_Y2) || ((tap == TAP_X1) && in_hp);
    mac_operand    = '0;
    mac_coef       = '0;
    case (tap)
      TAP_X0: begin
        mac_operand = in_hp ? lp_out_hist[0] : x_in;
        mac_coef    = in_hp ? high_b0 : low_b0;
      end
      TAP_X1: begin
        mac_operand = in_hp ? hp_in_hist[0] : lp_in_hist[0];
        mac_coef    = in_hp ? high_b0 : low_b0;
      end
      TAP_X2: begin
        mac_operand = in_hp ? hp_in_hist[1] : lp_in_hist[1];
        mac_coef    = in_hp ? high_b0 : low_b0;
      end
      TAP_Y1: begin
        mac_operand = in_hp ? hp_out_hist[0] : lp_out_hist[0];
        mac_coef    = in_hp ? high_a1 : low_a1;
      end
      TAP_Y2: begin
        mac_operand = in_hp ? hp_out_hist[1] : lp_out_hist[1];
        mac_coef    = in_hp ? high_a2 : low_a2;
      end
      default: ;
    endcase
  end

  bbc_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .operand (mac_operand),
    .coef    (mac_coef),
    .result  (mac_result)
  );

  // Input word latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x_in <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer and filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tap         <= TAP_X0;
      lp_in_hist  <= '{default: '0};
      lp_out_hist <= '{default: '0};
      hp_in_hist  <= '{default: '0};
      hp_out_hist <= '{default: '0};
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LP_MAC;
            tap   <= TAP_X0;
          end
        end
        ST_LP_MAC: begin
          tap <= tap + 1'b1;
          if (tap == TAP_LAST) begin
            state <= ST_LP_RND;
            tap   <= TAP_X0;
          end
        end
        ST_LP_RND: begin
          lp_in_hist  <= '{x_in, lp_in_hist[0]};
          lp_out_hist <= '{mac_result, lp_out_hist[0]};
          state       <= ST_HP_MAC;
        end
        ST_HP_MAC: begin
          tap <= tap + 1'b1;
          if (tap == TAP_LAST) begin
            state <= ST_HP_RND;
            tap   <= TAP_X0;
          end
        end
        ST_HP_RND: begin
          if (out_free) begin
            hp_in_hist  <= '{lp_out_hist[0], hp_in_hist[0]};
            hp_out_hist <= '{mac_result, hp_out_hist[0]};
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_HP_RND && out_free) begin
      out_sample <= mac_result;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_HP_RND && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ sim/bbc_band_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for biquad_bandpass_cascade: tracks coefficient writes, predicts every
// band-passed sample from the accepted input words and checks the output words in order.
// Depends on bbc_pkg for the register indexes and widths.

module bbc_band_checker import bbc_pkg::*; #(
  parameter int TDATA_W = ((DEF_SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [TDATA_W-1:0]      s_tdata,      // [15:0] sample_in
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [TDATA_W-1:0]      m_tdata,      // [15:0] sample_out
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data,
  output int                      fail_count,
  output int                      outstanding
);

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int FB = DEF_COEF_FRAC_BITS;
  localparam int REPORT_MAX = 10;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FB - 1);

  typedef logic signed [SB-1:0]        sample_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // Direct Form I history of one stage, newest first
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } stage_hist_t;

  typedef struct packed {
    sample_t sample_in;
    sample_t band;
  } band_word_t;

  coef_t       low_b0, low_a1, low_a2;
  coef_t       high_b0, high_a1, high_a2;
  stage_hist_t low_hist, high_hist;
  band_word_t  expected_band_q[$];
  int          errs;

  // One biquad update; the new output ends up in y1 of the returned history
  function automatic stage_hist_t biquad_stage(sample_t x, coef_t b0, logic high_pass,
                                               coef_t a1, coef_t a2, stage_hist_t h);
    logic signed [63:0] xw, x1w, x2w, y1w, y2w;
    logic signed [63:0] b0w, b1w, a1w, a2w, acc, q;
    stage_hist_t nh;
    xw  = x;
    x1w = h.x1;
    x2w = h.x2;
    y1w = h.y1;
    y2w = h.y2;
    b0w = b0;
    a1w = a1;
    a2w = a2;
    b1w = high_pass ? -2 * b0w : 2 * b0w;
    acc = b0w * xw + b1w * x1w + b0w * x2w - a1w * y1w - a2w * y2w + ROUND_HALF;
    q   = acc >>> FB;
    nh.x2 = h.x1;
    nh.x1 = x;
    nh.y2 = h.y1;
    if (q > SAT_HI)
      nh.y1 = SAT_HI[SB-1:0];
    else if (q < SAT_LO)
      nh.y1 = SAT_LO[SB-1:0];
    else
      nh.y1 = q[SB-1:0];
    return nh;
  endfunction

  always @(posedge clk) begin : watch
    band_word_t w;
    if (rst) begin
      low_b0    = '0;
      low_a1    = '0;
      low_a2    = '0;
      high_b0   = '0;
      high_a1   = '0;
      high_a2   = '0;
      low_hist  = '0;
      high_hist = '0;
      expected_band_q.delete();
      errs = 0;
    end else begin
      // coefficient word; spare indexes leave everything as is
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_B0:  low_b0  = cfg_data;
          REG_LOW_A1:  low_a1  = cfg_data;
          REG_LOW_A2:  low_a2  = cfg_data;
          REG_HIGH_B0: high_b0 = cfg_data;
          REG_HIGH_A1: high_a1 = cfg_data;
          REG_HIGH_A2: high_a2 = cfg_data;
          default: ;
        endcase
      end

      // output word against the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_band_q.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("%0t: output word %0d with no input pending", $realtime,
                     $signed(m_tdata[SB-1:0]));
        end else begin
          w = expected_band_q.pop_front();
          if (m_tdata[SB-1:0] !== w.band) begin
            errs++;
            if (errs <= REPORT_MAX)
              $display("%0t: sample_out mismatch (sample_in %0d): expected %0d, got %0d",
                       $realtime, w.sample_in, w.band, $signed(m_tdata[SB-1:0]));
          end
        end
      end

      // input word: run both stages
      if (s_tvalid && s_tready) begin
        low_hist  = biquad_stage(s_tdata[SB-1:0], low_b0, 1'b0, low_a1, low_a2, low_hist);
        high_hist = biquad_stage(low_hist.y1, high_b0, 1'b1, high_a1, high_a2, high_hist);
        w.sample_in = s_tdata[SB-1:0];
        w.band      = high_hist.y1;
        expected_band_q.push_back(w);
      end
    end
    fail_count  <= errs;
    outstanding <= expected_band_q.size();
  end

endmodule

@@ sim/tb_biquad_bandpass_cascade.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for biquad_bandpass_cascade: coefficient phases, corner and random
// samples with random idling on both sides. Depends on bbc_pkg and bbc_band_checker.

module tb_biquad_bandpass_cascade;
  import bbc_pkg::*;

  localparam int TDATA_W        = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_WORDS    = 105;
  localparam int SETTLE_CYCLES  = 20;

  // indexes the block must ignore
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [COEF_BITS-1:0] COEF_MAX = 20'h7FFFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN = 20'h80000;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] low_b0;
    logic [COEF_BITS-1:0] low_a1;
    logic [COEF_BITS-1:0] low_a2;
    logic [COEF_BITS-1:0] high_b0;
    logic [COEF_BITS-1:0] high_a1;
    logic [COEF_BITS-1:0] high_a2;
  } coef_set_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic [TDATA_W-1:0]      s_tdata   = '0;
  logic                    m_tready  = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0]    cfg_data  = '0;
  logic                    s_tready, m_tvalid, cfg_ready;
  logic [TDATA_W-1:0]      m_tdata;

  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int unsigned rx_wait     = 0;
  idle_mode_t  tx_mode     = IDLE_NONE;
  idle_mode_t  rx_mode     = IDLE_NONE;

  biquad_bandpass_cascade DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbc_band_checker #(.TDATA_W(TDATA_W)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default:   return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic coef_set_t make_set(int lb0, int la1, int la2, int hb0, int ha1, int ha2);
    coef_set_t c;
    c.low_b0  = lb0[COEF_BITS-1:0];
    c.low_a1  = la1[COEF_BITS-1:0];
    c.low_a2  = la2[COEF_BITS-1:0];
    c.high_b0 = hb0[COEF_BITS-1:0];
    c.high_a1 = ha1[COEF_BITS-1:0];
    c.high_a2 = ha2[COEF_BITS-1:0];
    return c;
  endfunction

  // 8 kHz low-pass into 1 kHz high-pass at 48 kHz, Q3.16
  function automatic coef_set_t audio_band();
    return make_set(10163, -40650, 15775, 59742, -118968, 54461);
  endfunction

  function automatic int mild(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic coef_set_t pick_coefs();
    case ($urandom_range(0, 6))
      0: return audio_band();
      1: return {6{COEF_MAX}};
      2: return {6{COEF_MIN}};
      3: return '0;
      4: return make_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      default: return make_set(mild(32768), mild(131072), mild(65535),
                               mild(65536), mild(131072), mild(65535));
    endcase
  endfunction

  function automatic logic [TDATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'(mild(256));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: per word, hold m_tready low for a drawn number of cycles
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      rx_wait = pick_gap(rx_mode);
      m_tready <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      m_tready <= (rx_wait == 0);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [TDATA_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(tx_mode);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] value);
    int unsigned gap;
    gap = pick_gap(tx_mode);
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // spare writes go last so an aliased decode would clobber a live coefficient
  task automatic load_coefs(input coef_set_t c, input bit spare);
    write_coef(REG_LOW_B0,  c.low_b0);
    write_coef(REG_LOW_A1,  c.low_a1);
    write_coef(REG_LOW_A2,  c.low_a2);
    write_coef(REG_HIGH_B0, c.high_b0);
    write_coef(REG_HIGH_A1, c.high_a1);
    write_coef(REG_HIGH_A2, c.high_a2);
    if (spare) begin
      write_coef(REG_SPARE_6, COEF_BITS'($urandom));
      write_coef(REG_SPARE_7, COEF_BITS'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted word has come out
  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_corners();
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    s_tvalid <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: everything must come out as zero
    tx_mode = IDLE_SOME;
    rx_mode = IDLE_SOME;
    send_corners();

    // realistic band, saturating extremes of both signs
    load_coefs(audio_band(), 1'b1);
    send_corners();
    load_coefs({6{COEF_MAX}}, 1'b0);
    send_corners();
    load_coefs({6{COEF_MIN}}, 1'b1);
    send_corners();

    // random phases: coefficient set, idling pattern and samples all drawn
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_mode = idle_mode_t'($urandom_range(0, 2));
      rx_mode = idle_mode_t'($urandom_range(0, 2));
      load_coefs(pick_coefs(), $urandom_range(0, 1));
      for (int n = 0; n < PHASE_WORDS; n++)
        send_sample(pick_sample());
      s_tvalid <= 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ biquad_bandpass_cascade.f @@
rtl/core/bbc_pkg.sv
rtl/core/bbc_mac.sv
rtl/core/biquad_bandpass_cascade.sv
sim/bbc_band_checker.sv
sim/tb_biquad_bandpass_cascade.sv
